// ===== hdl/peer_wire_message_deframer_core_defines.svh =====
// Assertion macros used by the deframer parse stage (pwd_parse).
`ifndef PEER_WIRE_MESSAGE_DEFRAMER_CORE_DEFINES_SVH
`define PEER_WIRE_MESSAGE_DEFRAMER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define PWD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PWD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/pwd_pkg.sv =====
package pwd_pkg;

    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECT_HANDSHAKE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_FRAME_LENGTH = 1'd1;

    localparam logic        EXPECT_HANDSHAKE_RST = 1'b1;
    localparam logic [31:0] MAX_FRAME_LENGTH_RST = 32'h0010_0000;

    localparam logic [7:0] HS_RESERVED_BYTES = 8'd8;
    localparam logic [7:0] HS_ID_BYTES       = 8'd20;
    localparam logic [7:0] LEN_BYTES         = 8'd4;

    typedef enum logic [3:0] {
        PH_START,
        PH_PLEN,
        PH_PROTO,
        PH_RES,
        PH_HASH,
        PH_PEER,
        PH_LEN,
        PH_TYPE,
        PH_PAY,
        PH_DROP
    } t_phase;

    typedef enum logic [3:0] {
        ROLE_PROTO_LEN  = 4'd0,
        ROLE_PROTO      = 4'd1,
        ROLE_RESERVED   = 4'd2,
        ROLE_INFO_HASH  = 4'd3,
        ROLE_PEER_ID    = 4'd4,
        ROLE_LENGTH     = 4'd5,
        ROLE_TYPE       = 4'd6,
        ROLE_PAYLOAD    = 4'd7,
        ROLE_DROPPED    = 4'd8
    } t_role;

    typedef struct packed {
        logic [7:0] rx_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  byte_value;
        logic [3:0]  byte_role;
        logic [31:0] field_offset;
        logic [7:0]  frame_type;
        logic        heartbeat;
        logic        frame_end;
        logic        oversize;
    } t_out_word;

endpackage

// ===== hdl/pwd_stream_if.sv =====
interface pwd_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/pwd_in_reg.sv =====
module pwd_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pwd_stream_if.sink    i_rx,
    pwd_stream_if.source  o_word
);

    logic               r_valid;
    pwd_pkg::t_in_word  r_data;

    assign i_rx.ready   = !r_valid || o_word.ready;
    assign o_word.valid = r_valid;
    assign o_word.data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_data <= i_rx.data;
        end
    end

endmodule

// ===== hdl/pwd_parse.sv =====
`include "peer_wire_message_deframer_core_defines.svh"

module pwd_parse (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_expect_handshake,
    input  logic [31:0]   i_max_frame_length,
    pwd_stream_if.sink    i_word,
    pwd_stream_if.source  o_res
);

    pwd_pkg::t_phase    r_phase, n_phase;
    logic [31:0]        r_count, n_count;
    logic [31:0]        r_acc,   n_acc;
    logic [7:0]         r_plen,  n_plen;
    logic [7:0]         r_type,  n_type;

    logic               r_out_valid;
    pwd_pkg::t_out_word r_res;
    pwd_pkg::t_out_word res_c;

    logic               advance;
    logic               fire;
    logic [7:0]         b;
    pwd_pkg::t_phase    ph_eff;
    logic [31:0]        acc_eff;
    logic [31:0]        acc_shift;
    logic [32:0]        cnt_p1;
    logic [32:0]        cnt_p2;
    logic               field_last;
    logic               len_zero;
    logic               len_over;
    pwd_pkg::t_role     role_c;

    assign advance      = !r_out_valid || o_res.ready;
    assign fire         = i_word.valid && advance;
    assign i_word.ready = advance;
    assign o_res.valid  = r_out_valid;
    assign o_res.data   = r_res;

    assign b         = i_word.data.rx_byte;
    assign acc_eff   = (r_phase == pwd_pkg::PH_START) ? 32'd0 : r_acc;
    assign acc_shift = {acc_eff[23:0], b};
    assign cnt_p1    = {1'b0, r_count} + 33'd1;
    assign cnt_p2    = {1'b0, r_count} + 33'd2;
    assign len_zero  = (acc_shift == 32'd0);
    assign len_over  = (acc_shift > i_max_frame_length);

    always_comb begin
        if (r_phase == pwd_pkg::PH_START) begin
            ph_eff = i_expect_handshake ? pwd_pkg::PH_PLEN : pwd_pkg::PH_LEN;
        end else begin
            ph_eff = r_phase;
        end
    end

    // last byte of the current field
    always_comb begin
        unique case (ph_eff)
            pwd_pkg::PH_PROTO: field_last = (cnt_p1 >= {25'd0, r_plen});
            pwd_pkg::PH_RES:   field_last = (cnt_p1 >= {25'd0, pwd_pkg::HS_RESERVED_BYTES});
            pwd_pkg::PH_HASH,
            pwd_pkg::PH_PEER:  field_last = (cnt_p1 >= {25'd0, pwd_pkg::HS_ID_BYTES});
            pwd_pkg::PH_LEN:   field_last = (cnt_p1 >= {25'd0, pwd_pkg::LEN_BYTES});
            pwd_pkg::PH_TYPE:  field_last = (acc_eff <= 32'd1);
            pwd_pkg::PH_PAY:   field_last = (cnt_p2 >= {1'b0, acc_eff});
            pwd_pkg::PH_DROP:  field_last = (cnt_p1 >= {1'b0, acc_eff});
            default:           field_last = 1'b1;
        endcase
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_acc   = r_acc;
        n_plen  = r_plen;
        n_type  = r_type;
        if (fire) begin
            n_acc   = acc_eff;
            n_count = field_last ? 32'd0 : cnt_p1[31:0];
            unique case (ph_eff)
                pwd_pkg::PH_PLEN: begin
                    n_plen  = b;
                    n_count = 32'd0;
                    n_phase = (b != 8'd0) ? pwd_pkg::PH_PROTO : pwd_pkg::PH_RES;
                end
                pwd_pkg::PH_PROTO: begin
                    if (field_last) n_phase = pwd_pkg::PH_RES;
                    else            n_phase = ph_eff;
                end
                pwd_pkg::PH_RES: begin
                    if (field_last) n_phase = pwd_pkg::PH_HASH;
                    else            n_phase = ph_eff;
                end
                pwd_pkg::PH_HASH: begin
                    if (field_last) n_phase = pwd_pkg::PH_PEER;
                    else            n_phase = ph_eff;
                end
                pwd_pkg::PH_LEN: begin
                    n_acc = acc_shift;
                    if (!field_last)   n_phase = ph_eff;
                    else if (len_zero) n_phase = pwd_pkg::PH_LEN;
                    else if (len_over) n_phase = pwd_pkg::PH_DROP;
                    else               n_phase = pwd_pkg::PH_TYPE;
                end
                pwd_pkg::PH_TYPE: begin
                    n_type  = b;
                    n_count = 32'd0;
                    n_phase = field_last ? pwd_pkg::PH_LEN : pwd_pkg::PH_PAY;
                end
                pwd_pkg::PH_PEER,
                pwd_pkg::PH_PAY,
                pwd_pkg::PH_DROP: begin
                    if (field_last) n_phase = pwd_pkg::PH_LEN;
                    else            n_phase = ph_eff;
                end
                default: begin
                    n_phase = ph_eff;
                end
            endcase
        end
    end

    // result word
    always_comb begin
        res_c            = '0;
        res_c.byte_value = b;
        res_c.field_offset = r_count;
        role_c           = pwd_pkg::ROLE_PROTO_LEN;
        unique case (ph_eff)
            pwd_pkg::PH_PLEN:  role_c = pwd_pkg::ROLE_PROTO_LEN;
            pwd_pkg::PH_PROTO: role_c = pwd_pkg::ROLE_PROTO;
            pwd_pkg::PH_RES:   role_c = pwd_pkg::ROLE_RESERVED;
            pwd_pkg::PH_HASH:  role_c = pwd_pkg::ROLE_INFO_HASH;
            pwd_pkg::PH_PEER: begin
                role_c          = pwd_pkg::ROLE_PEER_ID;
                res_c.frame_end = field_last;
            end
            pwd_pkg::PH_LEN: begin
                role_c           = pwd_pkg::ROLE_LENGTH;
                res_c.heartbeat  = field_last && len_zero;
                res_c.frame_end  = field_last && len_zero;
                res_c.oversize   = field_last && !len_zero && len_over;
            end
            pwd_pkg::PH_TYPE: begin
                role_c           = pwd_pkg::ROLE_TYPE;
                res_c.frame_type = b;
                res_c.frame_end  = field_last;
            end
            pwd_pkg::PH_PAY: begin
                role_c           = pwd_pkg::ROLE_PAYLOAD;
                res_c.frame_type = r_type;
                res_c.frame_end  = field_last;
            end
            pwd_pkg::PH_DROP: begin
                role_c          = pwd_pkg::ROLE_DROPPED;
                res_c.frame_end = field_last;
            end
            default: begin
                role_c = pwd_pkg::ROLE_PROTO_LEN;
            end
        endcase
        res_c.byte_role = role_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= pwd_pkg::PH_START;
            r_count     <= 32'd0;
            r_acc       <= 32'd0;
            r_plen      <= 8'd0;
            r_type      <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_acc   <= n_acc;
            r_plen  <= n_plen;
            r_type  <= n_type;
            if (advance) begin
                r_out_valid <= i_word.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= res_c;
        end
    end

    `PWD_ASSERT_NEXT(a_no_return_to_start, i_clk, i_rst_n,
        r_phase != pwd_pkg::PH_START, r_phase != pwd_pkg::PH_START, "phase went back to start")
    `PWD_ASSERT_NEXT(a_oversize_drops, i_clk, i_rst_n,
        fire && res_c.oversize, r_phase == pwd_pkg::PH_DROP, "oversize length did not drop")
    `PWD_ASSERT_NOW(a_heartbeat_ends, i_clk, i_rst_n,
        r_out_valid && r_res.heartbeat,
        r_res.frame_end && r_res.byte_role == pwd_pkg::ROLE_LENGTH, "keep-alive not a frame end")
    `PWD_ASSERT_NOW(a_oversize_no_end, i_clk, i_rst_n,
        r_out_valid && r_res.oversize,
        !r_res.frame_end && r_res.byte_role == pwd_pkg::ROLE_LENGTH, "oversize on wrong byte")

endmodule

// ===== hdl/peer_wire_message_deframer_core.sv =====
// Peer wire deframer: labels each received byte with its role, field offset, message
// type and frame-end/keep-alive/oversize marks. One byte per cycle while o_res is ready;
// a byte's result word passes through the input register, then the result register that
// the per-byte state update feeds. The first byte after reset picks a handshake or a
// length field from expect_handshake; max_frame_length applies to the next length field
// that completes. Write configuration only while the block is idle.
module peer_wire_message_deframer_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [pwd_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  logic [pwd_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    pwd_stream_if.sink                            i_rx,
    pwd_stream_if.source                          o_res
);

    logic        r_expect_handshake;
    logic [31:0] r_max_frame_length;

    pwd_stream_if #(.T(pwd_pkg::t_in_word)) w_mid ();

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_handshake <= pwd_pkg::EXPECT_HANDSHAKE_RST;
            r_max_frame_length <= pwd_pkg::MAX_FRAME_LENGTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pwd_pkg::CFG_EXPECT_HANDSHAKE: r_expect_handshake <= i_cfg_data[0];
                pwd_pkg::CFG_MAX_FRAME_LENGTH: r_max_frame_length <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    pwd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .o_word  (w_mid)
    );

    pwd_parse u_parse (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_expect_handshake (r_expect_handshake),
        .i_max_frame_length (r_max_frame_length),
        .i_word             (w_mid),
        .o_res              (o_res)
    );

endmodule
